// ===== hdl/bba_pkg.sv =====
// Shared constants, codes and types of the buddy block allocator.
`timescale 1ns / 1ps
`default_nettype none
package bba_pkg;

  localparam int MAX_POOL_ORDER = 16;
  localparam int MIN_ORDER      = 5;
  localparam int SLOT_W         = MAX_POOL_ORDER - MIN_ORDER;
  localparam int SLOTS          = 1 << SLOT_W;
  localparam int ENTRY_W        = 7;
  localparam int ORD_W          = 5;
  localparam int OFF_W          = 16;
  localparam int USED_W         = 17;
  localparam int HDR_W          = 5;
  localparam int TOT_W          = OFF_W + 1;
  localparam int CNT_W          = SLOT_W + 1;

  // entry bit positions
  localparam int HEAD_POS = 6;
  localparam int FREE_POS = 5;

  // register indexes
  localparam logic [1:0] REG_POOL_ORDER   = 2'd0;
  localparam logic [1:0] REG_HEADER_BYTES = 2'd1;

  // reset values
  localparam logic [ORD_W-1:0] POOL_ORDER_RST   = ORD_W'(16);
  localparam logic [HDR_W-1:0] HEADER_BYTES_RST = HDR_W'(24);

  // operations
  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_NO_FIT  = 2'd1;
  localparam logic [1:0] ST_BAD_OFF = 2'd2;

  // controller states
  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CLEAR  = 4'd1;
  localparam logic [3:0] S_NEED   = 4'd2;
  localparam logic [3:0] S_SCAN   = 4'd3;
  localparam logic [3:0] S_PICK   = 4'd4;
  localparam logic [3:0] S_SPLIT  = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_FHEAD  = 4'd7;
  localparam logic [3:0] S_MISSUE = 4'd8;
  localparam logic [3:0] S_MCHK   = 4'd9;

  typedef logic [ENTRY_W-1:0] entry_t;

  function automatic entry_t make_entry(input logic head, input logic free,
                                        input logic [ORD_W-1:0] ord);
    make_entry = {head, free, ord};
  endfunction

endpackage
`default_nettype wire

// ===== hdl/bba_ram.sv =====
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module bba_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire                      clk,
  input  wire                      we,
  input  wire [$clog2(DEPTH)-1:0]  waddr,
  input  wire [WIDTH-1:0]          wdata,
  input  wire                      re,
  input  wire [$clog2(DEPTH)-1:0]  raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ===== hdl/buddy_block_allocator_unit.sv =====
// Top level of the buddy block allocator: controller, block table and result port.
`timescale 1ns / 1ps
`default_nettype none
// Binary buddy allocator over a pool of 2^pool_order bytes, in 32-byte slots.
// Input: a request is taken at a clock edge with start high and busy low.
// in_operation selects allocate (in_request_bytes) or free (in_free_offset).
// Output: one result per request, shown for one cycle with out_valid high;
// the receiver cannot stall, so a result is never held back.
// Config: cfg_ready is always high. Index 0 writes pool_order (saturated
// to 6..16) and reinitializes the pool; index 1 writes header_bytes.
// Work between the accepting edge and the result strobe runs on one block
// table memory with a single read port:
//   allocate: the scan walks every slot of the pool once, then one split
//             step per order between the found and the needed order.
//   allocate that cannot fit by size answers from the size check; no free block, after the scan.
//   free: merges with free buddies one step at a time (at most 11 merges);
//         a bad offset answers at the offset check or the head read.
// Reset and every pool_order write start a clearing pass over every table
// entry, one table entry a cycle; busy stays high and no request is taken then.
// Busy drops with the result strobe, so the next request can be taken at
// the edge that ends the result cycle.
module buddy_block_allocator_unit (
  input  wire                       clk,
  input  wire                       rst_n,
  input  wire                       start,
  output logic                      busy,
  input  wire                       in_operation,
  input  wire  [15:0]               in_request_bytes,
  input  wire  [15:0]               in_free_offset,
  output logic                      out_valid,
  output logic [1:0]                out_status,
  output logic [15:0]               out_block_offset,
  output logic [4:0]                out_block_order,
  output logic [16:0]               out_used_bytes,
  input  wire                       cfg_valid,
  output logic                      cfg_ready,
  input  wire  [1:0]                cfg_index,
  input  wire  [4:0]                cfg_data
);

  localparam int SW = bba_pkg::SLOT_W;
  localparam int OW = bba_pkg::ORD_W;

  logic [3:0]                     state_r, state_nxt;
  logic [OW-1:0]                  pool_r, pool_nxt;
  logic [bba_pkg::HDR_W-1:0]      hdr_r, hdr_nxt;
  logic [bba_pkg::USED_W-1:0]     used_r, used_nxt;
  logic [bba_pkg::OFF_W-1:0]      bytes_r, bytes_nxt;
  logic [bba_pkg::OFF_W-1:0]      off_r, off_nxt;
  logic [bba_pkg::CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                           pv_r, pv_nxt;
  logic [OW-1:0]                  need_r, need_nxt;
  logic                           bfound_r, bfound_nxt;
  logic [SW-1:0]                  bslot_r, bslot_nxt;
  logic [OW-1:0]                  border_r, border_nxt;
  logic [SW-1:0]                  slot_r, slot_nxt;
  logic [OW-1:0]                  ord_r, ord_nxt;

  logic                           ov_r, ov_nxt;
  logic [1:0]                     ost_r, ost_nxt;
  logic [bba_pkg::OFF_W-1:0]      ooff_r, ooff_nxt;
  logic [OW-1:0]                  oord_r, oord_nxt;

  logic                           ram_we, ram_re;
  logic [SW-1:0]                  ram_waddr, ram_raddr;
  bba_pkg::entry_t                ram_wdata, ram_rdata;

  logic                           accept;
  logic                           pool_wr;
  logic [OW-1:0]                  pool_sat;
  logic [bba_pkg::TOT_W-1:0]      total;
  logic [OW-1:0]                  msb;
  logic [OW-1:0]                  need_c;
  logic [bba_pkg::CNT_W-1:0]      nslots;
  logic                           rd_head, rd_free;
  logic [OW-1:0]                  rd_ord;
  logic [SW-1:0]                  buddy;
  logic [OW-1:0]                  ord_dn;
  logic [SW-1:0]                  upper;

  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;
  assign pool_wr   = cfg_valid && cfg_ready && (cfg_index == bba_pkg::REG_POOL_ORDER);
  assign busy      = (state_r != bba_pkg::S_IDLE);

  // saturate a written pool order
  always_comb begin
    if (cfg_data > OW'(bba_pkg::MAX_POOL_ORDER)) begin
      pool_sat = OW'(bba_pkg::MAX_POOL_ORDER);
    end else if (cfg_data < OW'(bba_pkg::MIN_ORDER + 1)) begin
      pool_sat = OW'(bba_pkg::MIN_ORDER + 1);
    end else begin
      pool_sat = cfg_data;
    end
  end

  // needed order: top set bit of the padded size, plus one, at least MIN_ORDER
  assign total = bba_pkg::TOT_W'(bytes_r) + bba_pkg::TOT_W'(hdr_r);
  always_comb begin
    msb = '0;
    for (int i = 0; i < bba_pkg::TOT_W; i++) begin
      if (total[i]) begin
        msb = OW'(i);
      end
    end
  end
  always_comb begin
    if (msb + OW'(1) < OW'(bba_pkg::MIN_ORDER)) begin
      need_c = OW'(bba_pkg::MIN_ORDER);
    end else begin
      need_c = msb + OW'(1);
    end
  end

  assign nslots  = bba_pkg::CNT_W'(1) << (pool_r - OW'(bba_pkg::MIN_ORDER));
  assign rd_head = ram_rdata[bba_pkg::HEAD_POS];
  assign rd_free = ram_rdata[bba_pkg::FREE_POS];
  assign rd_ord  = ram_rdata[OW-1:0];
  assign buddy   = slot_r ^ (SW'(1) << (ord_r - OW'(bba_pkg::MIN_ORDER)));
  assign ord_dn  = ord_r - OW'(1);
  assign upper   = bslot_r + (SW'(1) << (ord_dn - OW'(bba_pkg::MIN_ORDER)));

  // controller
  always_comb begin
    state_nxt  = state_r;
    pool_nxt   = pool_r;
    hdr_nxt    = hdr_r;
    used_nxt   = used_r;
    bytes_nxt  = bytes_r;
    off_nxt    = off_r;
    cnt_nxt    = cnt_r;
    pv_nxt     = pv_r;
    need_nxt   = need_r;
    bfound_nxt = bfound_r;
    bslot_nxt  = bslot_r;
    border_nxt = border_r;
    slot_nxt   = slot_r;
    ord_nxt    = ord_r;
    ov_nxt     = 1'b0;
    ost_nxt    = ost_r;
    ooff_nxt   = ooff_r;
    oord_nxt   = oord_r;
    ram_we     = 1'b0;
    ram_waddr  = '0;
    ram_wdata  = '0;
    ram_re     = 1'b0;
    ram_raddr  = '0;

    unique case (state_r)
      bba_pkg::S_IDLE: begin
        if (accept) begin
          bytes_nxt = in_request_bytes;
          off_nxt   = in_free_offset;
          state_nxt = (in_operation == bba_pkg::OP_ALLOC) ? bba_pkg::S_NEED
                                                          : bba_pkg::S_FCHK;
        end
      end
      bba_pkg::S_CLEAR: begin
        // sweep the table: slot zero holds the whole pool
        ram_we    = 1'b1;
        ram_waddr = cnt_r[SW-1:0];
        ram_wdata = (cnt_r == '0) ? bba_pkg::make_entry(1'b1, 1'b1, pool_r) : '0;
        cnt_nxt   = cnt_r + bba_pkg::CNT_W'(1);
        if (cnt_r == bba_pkg::CNT_W'(bba_pkg::SLOTS - 1)) begin
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_NEED: begin
        need_nxt   = need_c;
        cnt_nxt    = '0;
        pv_nxt     = 1'b0;
        bfound_nxt = 1'b0;
        if (need_c > pool_r) begin
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_NO_FIT;
          ooff_nxt  = '0;
          oord_nxt  = '0;
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          state_nxt = bba_pkg::S_SCAN;
        end
      end
      bba_pkg::S_SCAN: begin
        // issue one slot a cycle, judge the one read last cycle
        if (cnt_r < nslots) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_r[SW-1:0];
          slot_nxt  = cnt_r[SW-1:0];
          cnt_nxt   = cnt_r + bba_pkg::CNT_W'(1);
          pv_nxt    = 1'b1;
        end else begin
          pv_nxt = 1'b0;
        end
        if (pv_r && rd_head && rd_free && rd_ord >= need_r &&
            (!bfound_r || rd_ord < border_r)) begin
          bfound_nxt = 1'b1;
          bslot_nxt  = slot_r;
          border_nxt = rd_ord;
        end
        if (!pv_r && cnt_r == nslots) begin
          state_nxt = bba_pkg::S_PICK;
        end
      end
      bba_pkg::S_PICK: begin
        if (bfound_r) begin
          ord_nxt   = border_r;
          state_nxt = bba_pkg::S_SPLIT;
        end else begin
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_NO_FIT;
          ooff_nxt  = '0;
          oord_nxt  = '0;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_SPLIT: begin
        // peel off upper halves, then claim the lower block
        ram_we = 1'b1;
        if (ord_r > need_r) begin
          ram_waddr = upper;
          ram_wdata = bba_pkg::make_entry(1'b1, 1'b1, ord_dn);
          ord_nxt   = ord_dn;
        end else begin
          ram_waddr = bslot_r;
          ram_wdata = bba_pkg::make_entry(1'b1, 1'b0, need_r);
          used_nxt  = used_r + (bba_pkg::USED_W'(1) << need_r);
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_OK;
          ooff_nxt  = bba_pkg::OFF_W'(bslot_r) << bba_pkg::MIN_ORDER;
          oord_nxt  = need_r;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_FCHK: begin
        if (off_r[bba_pkg::MIN_ORDER-1:0] != '0 || (off_r >> pool_r) != '0) begin
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_BAD_OFF;
          ooff_nxt  = '0;
          oord_nxt  = '0;
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          ram_re    = 1'b1;
          ram_raddr = off_r[bba_pkg::OFF_W-1:bba_pkg::MIN_ORDER];
          slot_nxt  = off_r[bba_pkg::OFF_W-1:bba_pkg::MIN_ORDER];
          state_nxt = bba_pkg::S_FHEAD;
        end
      end
      bba_pkg::S_FHEAD: begin
        if (!rd_head || rd_free) begin
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_BAD_OFF;
          ooff_nxt  = '0;
          oord_nxt  = '0;
          state_nxt = bba_pkg::S_IDLE;
        end else begin
          ord_nxt   = rd_ord;
          used_nxt  = used_r - (bba_pkg::USED_W'(1) << rd_ord);
          state_nxt = bba_pkg::S_MISSUE;
        end
      end
      bba_pkg::S_MISSUE: begin
        if (ord_r < pool_r) begin
          ram_re    = 1'b1;
          ram_raddr = buddy;
          state_nxt = bba_pkg::S_MCHK;
        end else begin
          ram_we    = 1'b1;
          ram_waddr = slot_r;
          ram_wdata = bba_pkg::make_entry(1'b1, 1'b1, ord_r);
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_OK;
          ooff_nxt  = bba_pkg::OFF_W'(slot_r) << bba_pkg::MIN_ORDER;
          oord_nxt  = ord_r;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      bba_pkg::S_MCHK: begin
        ram_we = 1'b1;
        if (rd_head && rd_free && rd_ord == ord_r) begin
          // drop the upper half; the lower one is rewritten later
          ram_waddr = (buddy > slot_r) ? buddy : slot_r;
          ram_wdata = '0;
          slot_nxt  = (buddy < slot_r) ? buddy : slot_r;
          ord_nxt   = ord_r + OW'(1);
          state_nxt = bba_pkg::S_MISSUE;
        end else begin
          ram_waddr = slot_r;
          ram_wdata = bba_pkg::make_entry(1'b1, 1'b1, ord_r);
          ov_nxt    = 1'b1;
          ost_nxt   = bba_pkg::ST_OK;
          ooff_nxt  = bba_pkg::OFF_W'(slot_r) << bba_pkg::MIN_ORDER;
          oord_nxt  = ord_r;
          state_nxt = bba_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = bba_pkg::S_IDLE;
      end
    endcase

    // configuration writes
    if (cfg_valid && cfg_ready) begin
      if (cfg_index == bba_pkg::REG_POOL_ORDER) begin
        pool_nxt  = pool_sat;
        used_nxt  = '0;
        cnt_nxt   = '0;
        state_nxt = bba_pkg::S_CLEAR;
      end else if (cfg_index == bba_pkg::REG_HEADER_BYTES) begin
        hdr_nxt = cfg_data;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bba_pkg::S_CLEAR;
      pool_r  <= bba_pkg::POOL_ORDER_RST;
      hdr_r   <= bba_pkg::HEADER_BYTES_RST;
      used_r  <= '0;
      cnt_r   <= '0;
      pv_r    <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pool_r  <= pool_nxt;
      hdr_r   <= hdr_nxt;
      used_r  <= used_nxt;
      cnt_r   <= cnt_nxt;
      pv_r    <= pv_nxt;
      ov_r    <= ov_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    bytes_r  <= bytes_nxt;
    off_r    <= off_nxt;
    need_r   <= need_nxt;
    bfound_r <= bfound_nxt;
    bslot_r  <= bslot_nxt;
    border_r <= border_nxt;
    slot_r   <= slot_nxt;
    ord_r    <= ord_nxt;
    ost_r    <= ost_nxt;
    ooff_r   <= ooff_nxt;
    oord_r   <= oord_nxt;
  end

  // block table
  bba_ram #(
    .WIDTH (bba_pkg::ENTRY_W),
    .DEPTH (bba_pkg::SLOTS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid        = ov_r;
  assign out_status       = ost_r;
  assign out_block_offset = ooff_r;
  assign out_block_order  = oord_r;
  assign out_used_bytes   = used_r;

  // a request always starts work on the next cycle
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && !cfg_valid) |=> busy)
    else $error("accepted request did not raise busy");

  // result strobe lasts one cycle
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe held for two cycles");

  // a pool order write starts the clearing pass
  a_pool_clear: assert property (@(posedge clk) disable iff (!rst_n)
    pool_wr |=> (state_r == bba_pkg::S_CLEAR && cnt_r == '0 && used_r == '0))
    else $error("pool write did not restart the table sweep");

  // a good result names a block at least the minimum order
  a_ok_order: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == bba_pkg::ST_OK) |->
      (out_block_order >= OW'(bba_pkg::MIN_ORDER) && out_block_order <= pool_r))
    else $error("result order out of range");

endmodule
`default_nettype wire

// ===== tb/sv/buddy_block_allocator_checker.sv =====
// Checker for the buddy block allocator: predicts each request's result and compares.
`timescale 1ns / 1ps
module buddy_block_allocator_checker
  import bba_pkg::*;
(
  input  wire         clk,
  input  wire         rst_n,
  input  wire         start,
  input  wire         busy,
  input  wire         in_operation,
  input  wire  [15:0] in_request_bytes,
  input  wire  [15:0] in_free_offset,
  input  wire         out_valid,
  input  wire  [1:0]  out_status,
  input  wire  [15:0] out_block_offset,
  input  wire  [4:0]  out_block_order,
  input  wire  [16:0] out_used_bytes,
  input  wire         cfg_valid,
  input  wire         cfg_ready,
  input  wire  [1:0]  cfg_index,
  input  wire  [4:0]  cfg_data,
  output int          fail_count,
  output int          pending,
  output int          result_count
);

  typedef struct packed {
    logic [1:0]        status;
    logic [OFF_W-1:0]  offset;
    logic [ORD_W-1:0]  order;
    logic [USED_W-1:0] used;
  } block_result_t;

  // shadow allocator state
  entry_t          slot_table [SLOTS];
  int unsigned     pool_ord;
  int unsigned     hdr_bytes;
  int unsigned     used_total;
  block_result_t   expected_results [$];

  function automatic block_result_t make_result(logic [1:0] st, int unsigned off,
                                                int unsigned ord);
    block_result_t r;
    r.status = st;
    r.offset = OFF_W'(off);
    r.order  = ORD_W'(ord);
    r.used   = USED_W'(used_total);
    return r;
  endfunction

  function automatic bit free_head_at(int unsigned slot, int unsigned ord);
    entry_t e;
    e = slot_table[slot];
    return e[HEAD_POS] && e[FREE_POS] && (int'(e[ORD_W-1:0]) == ord);
  endfunction

  task automatic clear_pool();
    foreach (slot_table[i]) slot_table[i] = '0;
    slot_table[0] = {1'b1, 1'b1, ORD_W'(pool_ord)};
    used_total = 0;
  endtask

  // carve the smallest free block of sufficient order, lowest slot first
  function automatic block_result_t predict_alloc(int unsigned bytes);
    int unsigned total, need, nslots, found, ord, upper;
    bit hit;
    total = bytes + hdr_bytes;
    need = 0;
    found = 0;
    hit = 0;
    while (total > 1) begin
      total = total >> 1;
      need++;
    end
    need++;
    if (need < MIN_ORDER) need = MIN_ORDER;
    if (need > pool_ord) return make_result(ST_NO_FIT, 0, 0);
    nslots = 1 << (pool_ord - MIN_ORDER);
    for (ord = need; ord <= pool_ord; ord++) begin
      for (int unsigned s = 0; s < nslots; s++) begin
        if (free_head_at(s, ord)) begin
          found = s;
          hit = 1;
          break;
        end
      end
      if (hit) break;
    end
    if (!hit) return make_result(ST_NO_FIT, 0, 0);
    while (ord > need) begin
      ord--;
      upper = found + (1 << (ord - MIN_ORDER));
      slot_table[found] = {1'b1, 1'b1, ORD_W'(ord)};
      slot_table[upper] = {1'b1, 1'b1, ORD_W'(ord)};
    end
    slot_table[found] = {1'b1, 1'b0, ORD_W'(need)};
    used_total += 1 << need;
    return make_result(ST_OK, found << MIN_ORDER, need);
  endfunction

  // release a block and merge with free buddies
  function automatic block_result_t predict_free(int unsigned off);
    int unsigned slot, bslot, ord;
    entry_t e;
    if ((off % (1 << MIN_ORDER)) != 0 || off >= (1 << pool_ord))
      return make_result(ST_BAD_OFF, 0, 0);
    slot = off >> MIN_ORDER;
    e = slot_table[slot];
    if (!e[HEAD_POS] || e[FREE_POS]) return make_result(ST_BAD_OFF, 0, 0);
    ord = e[ORD_W-1:0];
    used_total -= 1 << ord;
    while (ord < pool_ord) begin
      bslot = (off ^ (1 << ord)) >> MIN_ORDER;
      if (!free_head_at(bslot, ord)) break;
      slot_table[slot] = '0;
      slot_table[bslot] = '0;
      if (bslot < slot) slot = bslot;
      off = slot << MIN_ORDER;
      ord++;
    end
    slot_table[slot] = {1'b1, 1'b1, ORD_W'(ord)};
    return make_result(ST_OK, off, ord);
  endfunction

  assign pending = expected_results.size();

  initial begin
    fail_count = 0;
    result_count = 0;
  end

  always @(posedge clk) begin
    block_result_t want;
    block_result_t got;
    int unsigned v;
    if (!rst_n) begin
      pool_ord = POOL_ORDER_RST;
      hdr_bytes = HEADER_BYTES_RST;
      clear_pool();
      expected_results.delete();
    end else begin
      // compare a result with the oldest expectation
      if (out_valid) begin
        result_count++;
        got = {out_status, out_block_offset, out_block_order, out_used_bytes};
        if (expected_results.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("ERROR: unexpected result status=%0d offset=%0d order=%0d used=%0d",
                     out_status, out_block_offset, out_block_order, out_used_bytes);
        end else begin
          want = expected_results.pop_front();
          if (got !== want) begin
            fail_count++;
            if (fail_count <= 10)
              $display({"ERROR: result mismatch exp st=%0d off=%0d ord=%0d used=%0d",
                        " got st=%0d off=%0d ord=%0d used=%0d"},
                       want.status, want.offset, want.order, want.used,
                       got.status, got.offset, got.order, got.used);
          end
        end
      end
      // predict an accepted request
      if (start && !busy) begin
        if (in_operation == OP_ALLOC)
          expected_results.push_back(predict_alloc(in_request_bytes));
        else
          expected_results.push_back(predict_free(in_free_offset));
      end
      // track register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_POOL_ORDER) begin
          v = cfg_data;
          if (v > MAX_POOL_ORDER) v = MAX_POOL_ORDER;
          if (v < MIN_ORDER + 1) v = MIN_ORDER + 1;
          pool_ord = v;
          clear_pool();
        end else if (cfg_index == REG_HEADER_BYTES) begin
          hdr_bytes = cfg_data;
        end
      end
    end
  end

endmodule

// ===== tb/sv/buddy_block_allocator_unit_test.sv =====
// Top of the buddy block allocator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module buddy_block_allocator_unit_test;
  import bba_pkg::*;

  localparam int STALL_LIMIT = 20000;

  logic        clk;
  logic        rst_n;
  logic        start;
  logic        busy;
  logic        in_operation;
  logic [15:0] in_request_bytes;
  logic [15:0] in_free_offset;
  logic        out_valid;
  logic [1:0]  out_status;
  logic [15:0] out_block_offset;
  logic [4:0]  out_block_order;
  logic [16:0] out_used_bytes;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [4:0]  cfg_data;

  int          fail_count;
  int          pending;
  int          result_count;
  int          stall_cycles;
  int          request_count;
  int          cfg_count;
  int          idle_pct;
  int unsigned live_offsets [$];
  int unsigned cur_pool;

  buddy_block_allocator_unit dut (
    .clk, .rst_n, .start, .busy, .in_operation, .in_request_bytes, .in_free_offset,
    .out_valid, .out_status, .out_block_offset, .out_block_order, .out_used_bytes,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  buddy_block_allocator_checker checker_i (
    .clk, .rst_n, .start, .busy, .in_operation, .in_request_bytes, .in_free_offset,
    .out_valid, .out_status, .out_block_offset, .out_block_order, .out_used_bytes,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .fail_count, .pending, .result_count
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles + 1 >= STALL_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // issue one request and wait for its result
  task automatic send_request(logic op, logic [15:0] bytes, logic [15:0] off);
    int idx;
    in_operation     <= op;
    in_request_bytes <= bytes;
    in_free_offset   <= off;
    start            <= 1'b1;
    do @(posedge clk); while (busy);
    start <= 1'b0;
    do @(posedge clk); while (!out_valid);
    request_count++;
    if (out_status == ST_OK) begin
      if (op == OP_ALLOC) begin
        live_offsets.push_back(out_block_offset);
      end else begin
        idx = -1;
        foreach (live_offsets[i]) if (live_offsets[i] == off) idx = i;
        if (idx >= 0) live_offsets.delete(idx);
      end
    end
    if ($urandom_range(0, 99) < idle_pct) repeat ($urandom_range(1, 8)) @(posedge clk);
  endtask

  // write one register once no result is pending
  task automatic write_reg(logic [1:0] idx, logic [4:0] val);
    while (pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_count++;
    if (idx == REG_POOL_ORDER) begin
      live_offsets.delete();
      cur_pool = (val > MAX_POOL_ORDER) ? MAX_POOL_ORDER :
                 (val < MIN_ORDER + 1) ? MIN_ORDER + 1 : val;
    end
  endtask

  // mostly well-formed alloc/free traffic with some noise
  task automatic random_requests(int count);
    int unsigned bytes;
    int unsigned off;
    for (int n = 0; n < count; n++) begin
      if (n == count / 2) begin
        // hold off until the block has drained
        while (pending != 0) @(posedge clk);
        repeat ($urandom_range(2, 20)) @(posedge clk);
      end
      if ($urandom_range(0, 99) < 55 || live_offsets.size() == 0) begin
        if ($urandom_range(0, 19) == 0) bytes = $urandom_range(0, 16'hFFFF);
        else bytes = $urandom % (1 << $urandom_range(1, cur_pool - 1));
        send_request(OP_ALLOC, 16'(bytes), 16'($urandom));
      end else begin
        case ($urandom_range(0, 9))
          0:       off = $urandom_range(0, 16'hFFFF);
          1:       off = $urandom_range(0, (1 << cur_pool) - 1) & ~32'h1F;
          default: off = live_offsets[$urandom_range(0, live_offsets.size() - 1)];
        endcase
        send_request(OP_FREE, 16'($urandom), 16'(off));
      end
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_operation = OP_ALLOC;
    in_request_bytes = '0;
    in_free_offset = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_POOL_ORDER;
    cfg_data = '0;
    stall_cycles = 0;
    request_count = 0;
    cfg_count = 0;
    idle_pct = 11;
    cur_pool = POOL_ORDER_RST;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: whole pool, exhaustion, bad frees, split and merge cascade
    send_request(OP_ALLOC, 16'd40000, 16'h0000);
    send_request(OP_ALLOC, 16'd1, 16'hFFFF);
    send_request(OP_ALLOC, 16'hFFFF, 16'h0000);
    send_request(OP_FREE, 16'h0000, 16'h0000);
    send_request(OP_FREE, 16'hFFFF, 16'h0000);
    send_request(OP_FREE, 16'h0000, 16'h0003);
    send_request(OP_FREE, 16'h0000, 16'hFFE0);
    send_request(OP_FREE, 16'h0000, 16'hFFFF);
    send_request(OP_ALLOC, 16'd0, 16'h0000);
    send_request(OP_ALLOC, 16'd8, 16'h0000);
    send_request(OP_ALLOC, 16'd100, 16'h0000);
    send_request(OP_FREE, 16'h0000, 16'h0020);
    send_request(OP_FREE, 16'h0000, 16'h0000);
    send_request(OP_FREE, 16'h0000, 16'h0040);
    send_request(OP_ALLOC, 16'd32743, 16'h0000);
    send_request(OP_ALLOC, 16'd32744, 16'h0000);
    live_offsets.delete();
    random_requests(30);

    // small pool, no header
    write_reg(REG_POOL_ORDER, 5'd6);
    write_reg(REG_HEADER_BYTES, 5'd0);
    send_request(OP_ALLOC, 16'd32, 16'h0000);
    send_request(OP_ALLOC, 16'd31, 16'h0000);
    send_request(OP_ALLOC, 16'd0, 16'h0000);
    random_requests(70);

    // oversized write saturates to the largest pool
    write_reg(REG_POOL_ORDER, 5'd31);
    write_reg(REG_HEADER_BYTES, 5'd31);
    random_requests(20);

    // undersized write saturates to the smallest pool
    write_reg(REG_POOL_ORDER, 5'd0);
    random_requests(60);

    // a long stretch without sender gaps
    idle_pct = 0;
    write_reg(REG_POOL_ORDER, 5'd9);
    write_reg(REG_HEADER_BYTES, 5'd7);
    random_requests(120);
    idle_pct = 11;

    write_reg(REG_POOL_ORDER, 5'd8);
    write_reg(REG_HEADER_BYTES, 5'd13);
    random_requests(120);

    write_reg(REG_POOL_ORDER, 5'd11);
    write_reg(REG_HEADER_BYTES, 5'd2);
    random_requests(110);

    // drain and settle
    while (pending != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    $display("Covered %0d alloc/free requests, %0d results, %0d register writes,",
             request_count, result_count, cfg_count);
    $display("pool orders 6 to 16 with header sizes 0 to 31.");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/bba_pkg.sv
hdl/bba_ram.sv
hdl/buddy_block_allocator_unit.sv
tb/sv/buddy_block_allocator_checker.sv
tb/sv/buddy_block_allocator_unit_test.sv
